/* hw/rtl/shw_pkg.sv */
// Shared types, constants and round functions for the SHA-256 message hasher.
`timescale 1ns / 1ps
package shw_pkg;

	localparam int unsigned FifoDepth = 4;

	typedef enum logic [2:0] {
		B_IDLE,
		B_ROUND,
		B_ADD,
		B_PAD,
		B_OUT
	} back_state_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

	localparam logic [7:0] PadByte = 8'h80;

	function automatic logic [31:0] init_h(input logic [2:0] i);
		logic [31:0] r;
		case (i)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] r;
		case (i)
			6'd0: r = 32'h428a2f98; 6'd1: r = 32'h71374491; 6'd2: r = 32'hb5c0fbcf;
			6'd3: r = 32'he9b5dba5; 6'd4: r = 32'h3956c25b; 6'd5: r = 32'h59f111f1;
			6'd6: r = 32'h923f82a4; 6'd7: r = 32'hab1c5ed5; 6'd8: r = 32'hd807aa98;
			6'd9: r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
			6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
			6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
			6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
			6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
			6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
			6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
			6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
			6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
			default: r = 32'hc67178f2;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned s);
		return (v >> s) | (v << (32 - s));
	endfunction

	function automatic logic [31:0] big_s0(input logic [31:0] v);
		return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
	endfunction

	function automatic logic [31:0] big_s1(input logic [31:0] v);
		return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
	endfunction

	function automatic logic [31:0] small_s0(input logic [31:0] v);
		return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
	endfunction

	function automatic logic [31:0] small_s1(input logic [31:0] v);
		return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
	endfunction

endpackage

/* hw/rtl/shw_front.sv */
// Front end: accepts input items, drops empty ones and queues the rest.
`timescale 1ns / 1ps
module shw_front
	import shw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  item_t       in_item,
	output queue_head_t head,
	input  logic        pop
);

	localparam int unsigned PtrW = $clog2(FifoDepth);

	item_t             mem_q [FifoDepth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [PtrW:0]     count_q;
	logic              push;
	logic              do_pop;

	assign in_stall = (count_q == (PtrW+1)'(FifoDepth));
	assign push     = in_valid && !in_stall && (in_item.has_byte || in_item.end_of_message);
	assign do_pop   = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* hw/rtl/shw_core.sv */
// Back end: block packing, padding, 64-round compression and digest output.
`timescale 1ns / 1ps
module shw_core
	import shw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  queue_head_t head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	back_state_t state_q, state_d;

	logic [31:0] w_q     [16];
	logic [31:0] chain_q [8];
	logic [31:0] v_q     [8];
	logic [5:0]  cnt_q;
	logic [5:0]  rnd_q;
	logic [63:0] bitlen_q;
	logic [63:0] plen_q;
	logic        pad_q;
	logic        first_q;
	logic [3:0]  lc_q;
	logic        pend_end_q;
	logic [2:0]  oidx_q;
	logic        ovalid_q;
	logic [31:0] oword_q;
	logic [2:0]  oindex_q;
	logic        olast_q;

	logic        put_en;
	logic [7:0]  put_byte;
	logic        len_byte;
	logic        start_pad;
	logic        out_load;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] w_new;
	logic [3:0]  widx;
	logic [4:0]  wsh;

	assign out_load = (state_q == B_OUT) && (!ovalid_q || !out_stall);
	assign len_byte = !first_q && ((cnt_q == 6'd56) || (lc_q != '0));
	assign widx     = cnt_q[5:2];
	assign wsh      = {~cnt_q[1:0], 3'b000};

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		put_en    = 1'b0;
		put_byte  = head.item.data_byte;
		start_pad = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (head.valid) begin
					pop    = 1'b1;
					put_en = head.item.has_byte;
					if (head.item.has_byte && cnt_q == 6'd63) begin
						state_d = B_ROUND;
					end else if (head.item.end_of_message) begin
						start_pad = 1'b1;
						state_d   = B_PAD;
					end
				end
			end
			B_PAD: begin
				put_en = 1'b1;
				if (first_q) begin
					put_byte = PadByte;
				end else if (len_byte) begin
					put_byte = plen_q[63:56];
				end else begin
					put_byte = '0;
				end
				if (cnt_q == 6'd63) begin
					state_d = B_ROUND;
				end
			end
			B_ROUND: begin
				if (rnd_q == 6'd63) begin
					state_d = B_ADD;
				end
			end
			B_ADD: begin
				if (pad_q && lc_q == 4'd8) begin
					state_d = B_OUT;
				end else if (pad_q) begin
					state_d = B_PAD;
				end else if (pend_end_q) begin
					start_pad = 1'b1;
					state_d   = B_PAD;
				end else begin
					state_d = B_IDLE;
				end
			end
			B_OUT: begin
				if (out_load && oidx_q == 3'd7) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign t1 = v_q[7] + big_s1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ round_k(rnd_q) + w_q[0];
	assign t2 = big_s0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	assign w_new = small_s1(w_q[14]) + w_q[9] + small_s0(w_q[1]) + w_q[0];

	always_ff @(posedge clk) begin
		if (state_q == B_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
		end else if (put_en) begin
			w_q[widx][wsh +: 8] <= put_byte;
		end
		if (state_q == B_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end else if (state_d == B_ROUND) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= chain_q[i];
			end
		end
		if (pop && head.item.has_byte) begin
			plen_q <= bitlen_q + 64'd8;
		end else if (pop) begin
			plen_q <= bitlen_q;
		end else if (state_q == B_PAD && len_byte) begin
			plen_q <= {plen_q[55:0], 8'h00};
		end
		if (out_load) begin
			oword_q  <= chain_q[oidx_q];
			oindex_q <= oidx_q;
			olast_q  <= (oidx_q == 3'd7);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= init_h(3'(i));
			end
			cnt_q      <= '0;
			rnd_q      <= '0;
			bitlen_q   <= '0;
			pad_q      <= 1'b0;
			first_q    <= 1'b0;
			lc_q       <= '0;
			pend_end_q <= 1'b0;
			oidx_q     <= '0;
			ovalid_q   <= 1'b0;
		end else begin
			if (put_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (pop && head.item.has_byte) begin
				bitlen_q <= bitlen_q + 64'd8;
			end
			if (pop) begin
				pend_end_q <= head.item.end_of_message;
			end
			rnd_q <= (state_q == B_ROUND) ? rnd_q + 1'b1 : '0;
			if (state_q == B_ADD) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + v_q[i];
				end
			end
			if (start_pad) begin
				pad_q   <= 1'b1;
				first_q <= 1'b1;
				lc_q    <= '0;
			end else if (state_q == B_PAD) begin
				first_q <= 1'b0;
				if (len_byte) begin
					lc_q <= lc_q + 1'b1;
				end
			end
			if (out_load) begin
				ovalid_q <= 1'b1;
				oidx_q   <= oidx_q + 1'b1;
				if (oidx_q == 3'd7) begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= init_h(3'(i));
					end
					bitlen_q <= '0;
					pad_q    <= 1'b0;
				end
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = ovalid_q;
	assign digest_word = oword_q;
	assign word_index  = oindex_q;
	assign last_word   = olast_q;

	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_ROUND && rnd_q == 6'd63) |=> (state_q == B_ADD))
		else $error("round count did not end in the add step");
	a_out_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_OUT) |-> (cnt_q == '0 && lc_q == 4'd8))
		else $error("digest output with a partial block");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == B_IDLE))
		else $error("item taken outside idle");

endmodule

/* hw/rtl/sha256_message_hasher.sv */
// Top level of the SHA-256 message hasher.
// Input channel: in_valid / in_stall with data_byte, has_byte, end_of_message.
// An item with neither a byte nor the end mark is taken and dropped.
// Items go into a four-entry queue; the back end takes one at a time.
// Each byte is written into the block buffer; the 64th byte of a block starts
// the compression: 64 rounds and then an add step, during which the back end
// takes no item from the queue, which keeps accepting items until it is full.
// An end item runs the padding one byte per cycle, then one or two
// compressions, after which the digest leaves as eight words, word 0 first,
// on out_valid / out_stall with word_index and last_word on word 7.
// A digest word sits in an output register; while out_stall is high it holds
// and the back end waits, while the queue still accepts items until full.
// Reset (arst_n low) loads the initial hash words, clears the counts and the
// queue; the block is ready right after reset.
`timescale 1ns / 1ps
module sha256_message_hasher
	import shw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	item_t       in_item;
	queue_head_t head;
	logic        pop;

	assign in_item.data_byte      = data_byte;
	assign in_item.has_byte       = has_byte;
	assign in_item.end_of_message = end_of_message;

	shw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.head     (head),
		.pop      (pop)
	);

	shw_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

endmodule
